// ===== hw/rtl/rbp_pkg.sv =====
package rbp_pkg;

	// field widths
	localparam int DEPTH_W = 16;
	localparam int SCALE_W = 32;
	localparam int CTR_W   = 28;
	localparam int PIX_W   = 12;
	localparam int COLOR_W = 8;
	localparam int POSE_W  = 64;
	localparam int ROT_W   = 16;
	localparam int WORLD_W = 32;

	// datapath widths
	localparam int ZQ_W   = DEPTH_W + SCALE_W; // depth * scale, Q.24
	localparam int ZK_W   = 28;                // zq once known in range
	localparam int ZF_W   = 28;                // (zq * inv_focal) >> 32
	localparam int DMAG_W = 28;                // |col * 2^16 - center|
	localparam int CAM_W  = 33;                // signed camera x / y, Q.16
	localparam int CZ_W   = ZK_W - 8;          // camera z, Q.16
	localparam int PROD_W = ROT_W + CAM_W;     // rotation * camera coord, Q.30
	localparam int ACC_W  = PROD_W + 2;
	localparam int SH_W   = ACC_W - 14;        // rounded to Q.16
	localparam int SUM_W  = SH_W + 1;

	localparam int COORD_BITS_DEF = 12;

	// kept depth range in Q.24 metres: 0.01 .. 10.0
	localparam logic [ZQ_W-1:0] Z_MIN_Q24 = ZQ_W'(167773);
	localparam logic [ZQ_W-1:0] Z_MAX_Q24 = ZQ_W'(167772160);

	// configuration port
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SCALE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] CFG_POSE_ROW_X  = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] CFG_POSE_ROW_Y  = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] CFG_POSE_ROW_Z  = CFG_IDX_W'(7);

	localparam logic [SCALE_W-1:0] RST_DEPTH_SCALE = SCALE_W'(16777);
	localparam logic [SCALE_W-1:0] RST_INV_FOCAL   = SCALE_W'(8589934);
	localparam logic [CTR_W-1:0]   RST_CENTER_X    = CTR_W'(20971520);
	localparam logic [CTR_W-1:0]   RST_CENTER_Y    = CTR_W'(15728640);
	localparam logic [POSE_W-1:0]  RST_POSE_ROW_X  = POSE_W'(64'd16384);
	localparam logic [POSE_W-1:0]  RST_POSE_ROW_Y  = POSE_W'(64'd1073741824);
	localparam logic [POSE_W-1:0]  RST_POSE_ROW_Z  = POSE_W'(64'd70368744177664);

	typedef struct packed {
		logic [SCALE_W-1:0] depth_scale;
		logic [SCALE_W-1:0] inv_focal_x;
		logic [SCALE_W-1:0] inv_focal_y;
		logic [CTR_W-1:0]   center_x;
		logic [CTR_W-1:0]   center_y;
		logic [POSE_W-1:0]  pose_row_x;
		logic [POSE_W-1:0]  pose_row_y;
		logic [POSE_W-1:0]  pose_row_z;
	} cfg_t;

	// camera-frame point handed from the projection stages to the pose stages
	typedef struct packed {
		logic signed [CAM_W-1:0] cx;
		logic signed [CAM_W-1:0] cy;
		logic [CZ_W-1:0]         cz;
		logic [COLOR_W-1:0]      blue;
		logic [COLOR_W-1:0]      green;
		logic [COLOR_W-1:0]      red;
		logic                    ok;
		logic                    fend;
	} cam_t;

endpackage

// ===== hw/rtl/rgbd_depth_backprojection_top.sv =====
// RGBD pixel to world point back-projection.
// Slave stream: one pixel per beat, s_tlast marks the frame's last pixel.
// Master stream: one world point per kept pixel, Q15.16 metres, with its color;
// m_tuser is the point-valid flag, m_tlast marks the frame's last result.
// Pixels whose scaled depth is outside 0.01 m .. 10.0 m give no beat, except
// the frame's last pixel, which always gives one (point zero, flag low).
// Config channel: cfg_index selects depth_scale, inv_focal_x, inv_focal_y,
// center_x, center_y, pose_row_x/y/z (0..7); other indexes are ignored.
// cfg_ready is always high; write only while the pipe is empty.
// Throughput: one pixel per clock while m_tready is high, set by a
// six-stage pipeline (depth scale, z/f, pixel offset multiply,
// rotation products, dot-product sum, translation and saturation).
// When m_tready is low the pipe keeps filling its empty stages, then holds;
// s_tready drops only once every stage holds a beat. Nothing is lost.
// Reset clears all stage valids and loads the default intrinsics and the
// identity pose.
module rgbd_depth_backprojection_top #(
	parameter int COORD_BITS = rbp_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// depth_raw, blue, green, red, pixel_col, pixel_row
	input  logic [63:0]                   s_tdata,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// world_x, world_y, world_z, out_blue, out_green, out_red
	output logic [119:0]                  m_tdata,
	// point_valid
	output logic                          m_tuser,
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rbp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbp_pkg::POSE_W-1:0]    cfg_data
);
	import rbp_pkg::*;

	cfg_t cfg;
	cam_t cam;
	logic cam_valid, cam_ready;

	logic [WORLD_W-1:0] world_x, world_y, world_z;
	logic [COLOR_W-1:0] out_blue, out_green, out_red;

	rbp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rbp_camera #(
		.COORD_BITS (COORD_BITS)
	) u_camera (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.depth_raw (s_tdata[15:0]),
		.blue      (s_tdata[23:16]),
		.green     (s_tdata[31:24]),
		.red       (s_tdata[39:32]),
		.pixel_col (s_tdata[51:40]),
		.pixel_row (s_tdata[63:52]),
		.frame_end (s_tlast),
		.cfg       (cfg),
		.out_valid (cam_valid),
		.out_ready (cam_ready),
		.cam       (cam)
	);

	rbp_world u_world (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (cam_valid),
		.in_ready    (cam_ready),
		.cam         (cam),
		.cfg         (cfg),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.world_x     (world_x),
		.world_y     (world_y),
		.world_z     (world_z),
		.out_blue    (out_blue),
		.out_green   (out_green),
		.out_red     (out_red),
		.point_valid (m_tuser),
		.last        (m_tlast)
	);

	assign m_tdata = {out_red, out_green, out_blue, world_z, world_y, world_x};

endmodule

// ===== hw/rtl/rbp_cfg.sv =====
module rbp_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rbp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rbp_pkg::POSE_W-1:0]    cfg_data,
	output rbp_pkg::cfg_t                cfg
);
	import rbp_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth_scale <= RST_DEPTH_SCALE;
			cfg_q.inv_focal_x <= RST_INV_FOCAL;
			cfg_q.inv_focal_y <= RST_INV_FOCAL;
			cfg_q.center_x    <= RST_CENTER_X;
			cfg_q.center_y    <= RST_CENTER_Y;
			cfg_q.pose_row_x  <= RST_POSE_ROW_X;
			cfg_q.pose_row_y  <= RST_POSE_ROW_Y;
			cfg_q.pose_row_z  <= RST_POSE_ROW_Z;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DEPTH_SCALE: cfg_q.depth_scale <= cfg_data[SCALE_W-1:0];
				CFG_INV_FOCAL_X: cfg_q.inv_focal_x <= cfg_data[SCALE_W-1:0];
				CFG_INV_FOCAL_Y: cfg_q.inv_focal_y <= cfg_data[SCALE_W-1:0];
				CFG_CENTER_X:    cfg_q.center_x    <= cfg_data[CTR_W-1:0];
				CFG_CENTER_Y:    cfg_q.center_y    <= cfg_data[CTR_W-1:0];
				CFG_POSE_ROW_X:  cfg_q.pose_row_x  <= cfg_data;
				CFG_POSE_ROW_Y:  cfg_q.pose_row_y  <= cfg_data;
				CFG_POSE_ROW_Z:  cfg_q.pose_row_z  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/rbp_camera.sv =====
module rbp_camera #(
	parameter int COORD_BITS = rbp_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rbp_pkg::DEPTH_W-1:0] depth_raw,
	input  logic [rbp_pkg::COLOR_W-1:0] blue,
	input  logic [rbp_pkg::COLOR_W-1:0] green,
	input  logic [rbp_pkg::COLOR_W-1:0] red,
	input  logic [rbp_pkg::PIX_W-1:0]   pixel_col,
	input  logic [rbp_pkg::PIX_W-1:0]   pixel_row,
	input  logic                        frame_end,
	input  rbp_pkg::cfg_t               cfg,
	output logic                        out_valid,
	input  logic                        out_ready,
	output rbp_pkg::cam_t               cam
);
	import rbp_pkg::*;

	// only the low COORD_BITS of a pixel index take part
	localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((64'd1 << COORD_BITS) - 64'd1);

	logic en_s1, en_s2, en_s3;
	logic valid_s1, valid_s2, valid_s3;

	assign en_s3    = !valid_s3 || out_ready;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	// stage 1: depth scaling, signed pixel offsets from the principal point
	logic [PIX_W-1:0]    col_m, row_m;
	logic [DMAG_W:0]     dx, dy;
	logic [ZQ_W-1:0]     zq_s1;
	logic                dx_neg_s1, dy_neg_s1;
	logic [DMAG_W-1:0]   dx_mag_s1, dy_mag_s1;
	logic [COLOR_W-1:0]  blue_s1, green_s1, red_s1;
	logic                fend_s1;

	always_comb begin
		col_m = pixel_col & PIX_MASK;
		row_m = pixel_row & PIX_MASK;
		dx    = {1'b0, col_m, 16'h0000} - {1'b0, cfg.center_x};
		dy    = {1'b0, row_m, 16'h0000} - {1'b0, cfg.center_y};
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			zq_s1     <= ZQ_W'(depth_raw) * ZQ_W'(cfg.depth_scale);
			dx_neg_s1 <= dx[DMAG_W];
			dy_neg_s1 <= dy[DMAG_W];
			dx_mag_s1 <= dx[DMAG_W] ? DMAG_W'(-dx) : dx[DMAG_W-1:0];
			dy_mag_s1 <= dy[DMAG_W] ? DMAG_W'(-dy) : dy[DMAG_W-1:0];
			blue_s1   <= blue;
			green_s1  <= green;
			red_s1    <= red;
			fend_s1   <= frame_end;
		end
	end

	// stage 2: range check, z / f
	logic                ok;
	logic [ZF_W-1:0]     zfx_s2, zfy_s2;
	logic [CZ_W-1:0]     cz_s2;
	logic                ok_s2, fend_s2;
	logic                dx_neg_s2, dy_neg_s2;
	logic [DMAG_W-1:0]   dx_mag_s2, dy_mag_s2;
	logic [COLOR_W-1:0]  blue_s2, green_s2, red_s2;
	logic [ZK_W+SCALE_W-1:0] zfx_full, zfy_full;

	always_comb begin
		ok       = (zq_s1 >= Z_MIN_Q24) && (zq_s1 <= Z_MAX_Q24);
		zfx_full = (ZK_W+SCALE_W)'(zq_s1[ZK_W-1:0]) * (ZK_W+SCALE_W)'(cfg.inv_focal_x);
		zfy_full = (ZK_W+SCALE_W)'(zq_s1[ZK_W-1:0]) * (ZK_W+SCALE_W)'(cfg.inv_focal_y);
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			zfx_s2    <= zfx_full[ZK_W+SCALE_W-1:SCALE_W];
			zfy_s2    <= zfy_full[ZK_W+SCALE_W-1:SCALE_W];
			cz_s2     <= zq_s1[ZK_W-1:8];
			ok_s2     <= ok;
			fend_s2   <= fend_s1;
			dx_neg_s2 <= dx_neg_s1;
			dy_neg_s2 <= dy_neg_s1;
			dx_mag_s2 <= dx_mag_s1;
			dy_mag_s2 <= dy_mag_s1;
			blue_s2   <= blue_s1;
			green_s2  <= green_s1;
			red_s2    <= red_s1;
		end
	end

	// stage 3: camera x / y = sign(d) * (|d| * zf >> 24)
	logic [DMAG_W+ZF_W-1:0] mx, my;
	logic [CAM_W-1:0]       ux, uy;
	cam_t                   cam_s3;

	always_comb begin
		mx = (DMAG_W+ZF_W)'(dx_mag_s2) * (DMAG_W+ZF_W)'(zfx_s2);
		my = (DMAG_W+ZF_W)'(dy_mag_s2) * (DMAG_W+ZF_W)'(zfy_s2);
		ux = {1'b0, mx[DMAG_W+ZF_W-1:24]};
		uy = {1'b0, my[DMAG_W+ZF_W-1:24]};
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			cam_s3.cx    <= dx_neg_s2 ? -ux : ux;
			cam_s3.cy    <= dy_neg_s2 ? -uy : uy;
			cam_s3.cz    <= cz_s2;
			cam_s3.blue  <= blue_s2;
			cam_s3.green <= green_s2;
			cam_s3.red   <= red_s2;
			cam_s3.ok    <= ok_s2;
			cam_s3.fend  <= fend_s2;
		end
	end

	// out-of-range pixels leave the pipe here unless they close a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1 && (ok || fend_s1);
			if (en_s3) valid_s3 <= valid_s2;
		end
	end

	assign out_valid = valid_s3;
	assign cam       = cam_s3;

endmodule

// ===== hw/rtl/rbp_world.sv =====
module rbp_world (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rbp_pkg::cam_t               cam,
	input  rbp_pkg::cfg_t               cfg,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rbp_pkg::WORLD_W-1:0] world_x,
	output logic [rbp_pkg::WORLD_W-1:0] world_y,
	output logic [rbp_pkg::WORLD_W-1:0] world_z,
	output logic [rbp_pkg::COLOR_W-1:0] out_blue,
	output logic [rbp_pkg::COLOR_W-1:0] out_green,
	output logic [rbp_pkg::COLOR_W-1:0] out_red,
	output logic                        point_valid,
	output logic                        last
);
	import rbp_pkg::*;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(8192);

	logic en_s4, en_s5, en_s6;
	logic valid_s4, valid_s5, valid_s6;

	assign en_s6    = !valid_s6 || out_ready;
	assign en_s5    = !valid_s5 || en_s6;
	assign en_s4    = !valid_s4 || en_s5;
	assign in_ready = en_s4;

	logic [POSE_W-1:0]       pose [3];
	logic signed [CAM_W-1:0] cvec [3];

	always_comb begin
		pose[0] = cfg.pose_row_x;
		pose[1] = cfg.pose_row_y;
		pose[2] = cfg.pose_row_z;
		cvec[0] = cam.cx;
		cvec[1] = cam.cy;
		cvec[2] = CAM_W'({1'b0, cam.cz});
	end

	// stage 4: the nine rotation products, Q.30
	logic signed [PROD_W-1:0] prod_s4 [3][3];
	logic signed [ROT_W-1:0]  tr_s4 [3];
	logic [COLOR_W-1:0]       blue_s4, green_s4, red_s4;
	logic                     ok_s4, fend_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s4[a][k] <= PROD_W'($signed(pose[a][16*k +: ROT_W]))
						* PROD_W'(cvec[k]);
				end
				tr_s4[a] <= $signed(pose[a][48 +: ROT_W]);
			end
			blue_s4  <= cam.blue;
			green_s4 <= cam.green;
			red_s4   <= cam.red;
			ok_s4    <= cam.ok;
			fend_s4  <= cam.fend;
		end
	end

	// stage 5: dot product, round half up to Q.16
	logic signed [ACC_W-1:0] acc [3];
	logic signed [SH_W-1:0]  sh_s5 [3];
	logic signed [ROT_W-1:0] tr_s5 [3];
	logic [COLOR_W-1:0]      blue_s5, green_s5, red_s5;
	logic                    ok_s5, fend_s5;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			acc[a] = ACC_W'(prod_s4[a][0]) + ACC_W'(prod_s4[a][1])
				+ ACC_W'(prod_s4[a][2]) + ROUND_HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			for (int a = 0; a < 3; a++) begin
				sh_s5[a] <= SH_W'(acc[a] >>> 14);
				tr_s5[a] <= tr_s4[a];
			end
			blue_s5  <= blue_s4;
			green_s5 <= green_s4;
			red_s5   <= red_s4;
			ok_s5    <= ok_s4;
			fend_s5  <= fend_s4;
		end
	end

	// stage 6: add translation, saturate, zero a dropped frame-end pixel
	logic signed [SUM_W-1:0] wsum [3];
	logic [WORLD_W-1:0]      wsat [3];
	logic [WORLD_W-1:0]      world_s6 [3];
	logic [COLOR_W-1:0]      blue_s6, green_s6, red_s6;
	logic                    ok_s6, fend_s6;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			wsum[a] = SUM_W'(sh_s5[a]) + SUM_W'($signed({tr_s5[a], 8'h00}));
			if (&wsum[a][SUM_W-1:WORLD_W-1] || ~|wsum[a][SUM_W-1:WORLD_W-1]) begin
				wsat[a] = wsum[a][WORLD_W-1:0];
			end else if (wsum[a][SUM_W-1]) begin
				wsat[a] = {1'b1, {(WORLD_W-1){1'b0}}};
			end else begin
				wsat[a] = {1'b0, {(WORLD_W-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			for (int a = 0; a < 3; a++) begin
				world_s6[a] <= ok_s5 ? wsat[a] : '0;
			end
			blue_s6  <= blue_s5;
			green_s6 <= green_s5;
			red_s6   <= red_s5;
			ok_s6    <= ok_s5;
			fend_s6  <= fend_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s4) valid_s4 <= in_valid;
			if (en_s5) valid_s5 <= valid_s4;
			if (en_s6) valid_s6 <= valid_s5;
		end
	end

	assign out_valid   = valid_s6;
	assign world_x     = world_s6[0];
	assign world_y     = world_s6[1];
	assign world_z     = world_s6[2];
	assign out_blue    = blue_s6;
	assign out_green   = green_s6;
	assign out_red     = red_s6;
	assign point_valid = ok_s6;
	assign last        = fend_s6;

endmodule

// ===== bench/rgbd_depth_backprojection_top_tb.sv =====
`timescale 1ns / 1ps

module rgbd_depth_backprojection_top_tb;
	import rbp_pkg::*;

	localparam int COORD_BITS = COORD_BITS_DEF;
	localparam longint KEEP_MIN_Q24 = 167773;
	localparam longint KEEP_MAX_Q24 = 167772160;
	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;
	localparam int RAND_PHASES = 12;
	localparam int ITEMS_PER_PHASE = 62;
	localparam int SETTLE_CYCLES = 16;

	typedef struct packed {
		logic [15:0] depth;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [11:0] col;
		logic [11:0] row;
		logic        fend;
	} pixel_t;

	typedef struct packed {
		logic [31:0] wx;
		logic [31:0] wy;
		logic [31:0] wz;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic        valid;
		logic        last;
	} point_t;

	class point_tracker;
		logic [31:0] depth_scale;
		logic [31:0] inv_fx;
		logic [31:0] inv_fy;
		logic [27:0] ctr_x;
		logic [27:0] ctr_y;
		logic [63:0] pose [3];
		point_t points_due [$];
		int errors;

		function new();
			depth_scale = RST_DEPTH_SCALE;
			inv_fx = RST_INV_FOCAL;
			inv_fy = RST_INV_FOCAL;
			ctr_x = RST_CENTER_X;
			ctr_y = RST_CENTER_Y;
			pose[0] = RST_POSE_ROW_X;
			pose[1] = RST_POSE_ROW_Y;
			pose[2] = RST_POSE_ROW_Z;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
			case (idx)
				CFG_DEPTH_SCALE: depth_scale = val[31:0];
				CFG_INV_FOCAL_X: inv_fx = val[31:0];
				CFG_INV_FOCAL_Y: inv_fy = val[31:0];
				CFG_CENTER_X:    ctr_x = val[27:0];
				CFG_CENTER_Y:    ctr_y = val[27:0];
				CFG_POSE_ROW_X:  pose[0] = val;
				CFG_POSE_ROW_Y:  pose[1] = val;
				CFG_POSE_ROW_Z:  pose[2] = val;
				default: ;
			endcase
		endfunction

		// pixel offset from the principal point times z/f, truncated toward zero
		function longint cam_offset(logic [11:0] pix, logic [27:0] ctr, logic [63:0] zf);
			longint d;
			logic [63:0] mag;
			logic [63:0] m;
			d = $signed({36'd0, pix, 16'd0}) - $signed({36'd0, ctr});
			mag = (d < 0) ? -d : d;
			m = (mag * zf) >> 24;
			return (d < 0) ? -$signed(m) : $signed(m);
		endfunction

		function logic [31:0] to_world(logic [63:0] row, longint cx, longint cy, longint cz);
			logic signed [15:0] r0, r1, r2, tr;
			longint acc, v;
			r0 = row[15:0];
			r1 = row[31:16];
			r2 = row[47:32];
			tr = row[63:48];
			acc = r0 * cx + r1 * cy + r2 * cz;
			// Q.30 rounded half up to Q.16, translation Q8.8 -> Q.16
			v = ((acc + 64'sd8192) >>> 14) + tr * 64'sd256;
			if (v > SAT_HI)
				v = SAT_HI;
			if (v < SAT_LO)
				v = SAT_LO;
			return v[31:0];
		endfunction

		function void note_pixel(pixel_t p);
			logic [47:0] zq;
			logic [11:0] pix_mask;
			logic in_range;
			longint cx, cy, cz;
			point_t pt;
			pix_mask = 12'((1 << COORD_BITS) - 1);
			zq = p.depth * depth_scale;
			in_range = zq >= KEEP_MIN_Q24 && zq <= KEEP_MAX_Q24;
			if (!in_range && !p.fend)
				return;
			pt = '0;
			if (in_range) begin
				cx = cam_offset(p.col & pix_mask, ctr_x, (64'(zq) * 64'(inv_fx)) >> 32);
				cy = cam_offset(p.row & pix_mask, ctr_y, (64'(zq) * 64'(inv_fy)) >> 32);
				cz = $signed({16'd0, zq >> 8});
				pt.wx = to_world(pose[0], cx, cy, cz);
				pt.wy = to_world(pose[1], cx, cy, cz);
				pt.wz = to_world(pose[2], cx, cy, cz);
			end
			pt.blue = p.blue;
			pt.green = p.green;
			pt.red = p.red;
			pt.valid = in_range;
			pt.last = p.fend;
			points_due.insert(points_due.size(), pt);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_point(point_t got);
			point_t want;
			if (points_due.size() == 0) begin
				$display("%0t: unexpected point, expected none, got %h", $time, got);
				errors++;
				return;
			end
			want = points_due.pop_front();
			compare_field("world_x", want.wx, got.wx);
			compare_field("world_y", want.wy, got.wy);
			compare_field("world_z", want.wz, got.wz);
			compare_field("out_blue", want.blue, got.blue);
			compare_field("out_green", want.green, got.green);
			compare_field("out_red", want.red, got.red);
			compare_field("point_valid", want.valid, got.valid);
			compare_field("last", want.last, got.last);
		endfunction

		function int pending();
			return points_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [63:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [119:0] m_tdata;
	logic m_tuser;
	logic m_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [POSE_W-1:0] cfg_data;

	point_tracker tracker;
	logic [63:0] cfg_plan [8];
	int gap_pct;
	int stall_pct;
	int stall_left = 0;

	rgbd_depth_backprojection_top #(
		.COORD_BITS(COORD_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// receiver back-pressure in bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 15);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_point({m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
				m_tdata[103:96], m_tdata[111:104], m_tdata[119:112], m_tuser, m_tlast});
	end

	function automatic pixel_t mk_pixel(logic [15:0] depth, logic [7:0] blue, logic [7:0] green,
			logic [7:0] red, logic [11:0] col, logic [11:0] row, logic fend);
		pixel_t p;
		p.depth = depth;
		p.blue = blue;
		p.green = green;
		p.red = red;
		p.col = col;
		p.row = row;
		p.fend = fend;
		return p;
	endfunction

	// depths mostly inside the kept window of the current scale, some on its edges
	function automatic logic [15:0] pick_depth(logic [31:0] scale);
		longint lo, hi;
		int sel;
		sel = $urandom_range(0, 99);
		if (scale == 0 || sel >= 85)
			return 16'($urandom);
		lo = (KEEP_MIN_Q24 + scale - 1) / scale;
		hi = KEEP_MAX_Q24 / scale;
		if (lo > 65535 || lo > hi)
			return 16'($urandom);
		if (hi > 65535)
			hi = 65535;
		if (sel < 4)
			return 16'(lo - 1);
		if (sel < 8)
			return 16'(hi + 1);
		if (sel < 12)
			return 16'(lo);
		if (sel < 16)
			return 16'(hi);
		return 16'($urandom_range(int'(hi), int'(lo)));
	endfunction

	function automatic logic [11:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return 12'd0;
			1: return 12'hFFF;
			default: return 12'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] pick_reg(int unsigned typ_lo, int unsigned typ_hi,
			logic [63:0] top);
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return top;
			2: return {$urandom, $urandom};
			default: return 64'($urandom_range(typ_hi, typ_lo));
		endcase
	endfunction

	function automatic logic [15:0] pick_pose_field();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'h4000; // +1.0 in Q2.14
			4: return 16'hC000; // -1.0
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_pixel(pixel_t p);
		s_tvalid <= 1'b1;
		s_tdata <= {p.row, p.col, p.red, p.green, p.blue, p.depth};
		s_tlast <= p.fend;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.note_pixel(p);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16))
				@(posedge clk);
		end
	endtask

	// drop valid, wait for every point to come back, then let the pipe empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic load_config();
		logic [CFG_IDX_W-1:0] idx;
		logic [63:0] junk;
		for (int i = 0; i <= CFG_POSE_ROW_Z; i++) begin
			idx = CFG_IDX_W'(i);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= cfg_plan[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			tracker.write_reg(idx, cfg_plan[i]);
		end
		// index past the last register must be ignored
		idx = CFG_IDX_W'($urandom_range(CFG_POSE_ROW_Z + 1, 2**CFG_IDX_W - 1));
		junk = {$urandom, $urandom};
		cfg_index <= idx;
		cfg_data <= junk;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.write_reg(idx, junk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		#5ms;
		$display("rgbd_depth_backprojection_top regression: fail");
		$finish;
	end

	initial begin
		int frame_left;
		logic fend;
		tracker = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		gap_pct = 25;
		stall_pct = 25;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;

		// reset intrinsics: depth window is 11..10000 counts
		send_pixel(mk_pixel(16'd10, 8'h00, 8'h00, 8'h00, 12'd0, 12'd0, 1'b0));
		send_pixel(mk_pixel(16'd11, 8'hFF, 8'hFF, 8'hFF, 12'hFFF, 12'hFFF, 1'b0));
		send_pixel(mk_pixel(16'd10000, 8'h5A, 8'hA5, 8'h3C, 12'd0, 12'hFFF, 1'b0));
		send_pixel(mk_pixel(16'd10001, 8'h12, 8'h34, 8'h56, 12'd100, 12'd200, 1'b1));
		send_pixel(mk_pixel(16'd0, 8'h01, 8'h02, 8'h03, 12'd7, 12'd9, 1'b0));
		send_pixel(mk_pixel(16'hFFFF, 8'h80, 8'h7F, 8'hC3, 12'd640, 12'd480, 1'b1));
		send_pixel(mk_pixel(16'd5000, 8'h11, 8'h22, 8'h33, 12'd320, 12'd240, 1'b1));
		settle();

		// exact lower bound at one count, max focal reciprocal, saturating pose
		cfg_plan[CFG_DEPTH_SCALE] = 64'd167773;
		cfg_plan[CFG_INV_FOCAL_X] = 64'hFFFF_FFFF;
		cfg_plan[CFG_INV_FOCAL_Y] = 64'hFFFF_FFFF;
		cfg_plan[CFG_CENTER_X] = 64'd0;
		cfg_plan[CFG_CENTER_Y] = 64'd0;
		cfg_plan[CFG_POSE_ROW_X] = {4{16'h7FFF}};
		cfg_plan[CFG_POSE_ROW_Y] = {4{16'h8000}};
		cfg_plan[CFG_POSE_ROW_Z] = 64'd0;
		load_config();
		send_pixel(mk_pixel(16'd1, 8'h0F, 8'hF0, 8'hAA, 12'hFFF, 12'hFFF, 1'b0));
		send_pixel(mk_pixel(16'd0, 8'h55, 8'h66, 8'h77, 12'd1, 12'd1, 1'b1));
		send_pixel(mk_pixel(16'd1000, 8'h99, 8'h88, 8'h77, 12'd2, 12'd3, 1'b0));
		send_pixel(mk_pixel(16'd999, 8'hFE, 8'hEF, 8'h01, 12'hFFF, 12'd0, 1'b1));
		settle();

		// exact upper bound at two counts, zero focal reciprocal, max center
		cfg_plan[CFG_DEPTH_SCALE] = 64'd83886080;
		cfg_plan[CFG_INV_FOCAL_X] = 64'd0;
		cfg_plan[CFG_INV_FOCAL_Y] = 64'd0;
		cfg_plan[CFG_CENTER_X] = 64'h0FFF_FFFF;
		cfg_plan[CFG_CENTER_Y] = 64'h0FFF_FFFF;
		cfg_plan[CFG_POSE_ROW_X] = RST_POSE_ROW_X;
		cfg_plan[CFG_POSE_ROW_Y] = RST_POSE_ROW_Y;
		cfg_plan[CFG_POSE_ROW_Z] = RST_POSE_ROW_Z;
		load_config();
		send_pixel(mk_pixel(16'd2, 8'h10, 8'h20, 8'h30, 12'd0, 12'd0, 1'b0));
		send_pixel(mk_pixel(16'd3, 8'h40, 8'h50, 8'h60, 12'hFFF, 12'd5, 1'b1));
		send_pixel(mk_pixel(16'd1, 8'h70, 8'h80, 8'h90, 12'd2048, 12'd17, 1'b1));
		settle();

		// zero depth scale drops everything; only the frame end reports
		cfg_plan[CFG_DEPTH_SCALE] = 64'd0;
		load_config();
		send_pixel(mk_pixel(16'hFFFF, 8'hA0, 8'hB0, 8'hC0, 12'd12, 12'd34, 1'b0));
		send_pixel(mk_pixel(16'd1, 8'hD0, 8'hE0, 8'hF0, 12'd56, 12'd78, 1'b1));
		settle();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			cfg_plan[CFG_DEPTH_SCALE] = pick_reg(2000, 200000, 64'hFFFF_FFFF);
			cfg_plan[CFG_INV_FOCAL_X] = pick_reg(2000000, 30000000, 64'hFFFF_FFFF);
			cfg_plan[CFG_INV_FOCAL_Y] = pick_reg(2000000, 30000000, 64'hFFFF_FFFF);
			cfg_plan[CFG_CENTER_X] = pick_reg(0, 32'h0FFF_0000, 64'h0FFF_FFFF);
			cfg_plan[CFG_CENTER_Y] = pick_reg(0, 32'h0FFF_0000, 64'h0FFF_FFFF);
			cfg_plan[CFG_POSE_ROW_X] = {pick_pose_field(), pick_pose_field(),
				pick_pose_field(), pick_pose_field()};
			cfg_plan[CFG_POSE_ROW_Y] = {pick_pose_field(), pick_pose_field(),
				pick_pose_field(), pick_pose_field()};
			cfg_plan[CFG_POSE_ROW_Z] = {pick_pose_field(), pick_pose_field(),
				pick_pose_field(), pick_pose_field()};
			load_config();
			if (ph == RAND_PHASES - 1) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
				stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
			end
			frame_left = 0;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (frame_left == 0)
					frame_left = $urandom_range(1, 24);
				fend = (frame_left == 1) || (i == ITEMS_PER_PHASE - 1);
				frame_left = fend ? 0 : frame_left - 1;
				send_pixel(mk_pixel(pick_depth(cfg_plan[CFG_DEPTH_SCALE][31:0]),
					8'($urandom), 8'($urandom), 8'($urandom),
					pick_coord(), pick_coord(), fend));
			end
			settle();
		end

		if (tracker.errors == 0)
			$display("rgbd_depth_backprojection_top regression: pass");
		else
			$display("rgbd_depth_backprojection_top regression: fail");
		$finish;
	end

endmodule
